// ===== hw/rtl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared constants and the payload beat type passed from the parser to the
// output stage.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // Widths of the stream fields.
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned OpcodeWidth = 4;
   localparam int unsigned LenWidth    = 64;
   localparam int unsigned KeyWidth    = 32;

   // The opcode delivered after reset (text frames).
   localparam logic [OpcodeWidth-1:0] OPCODE_RESET = 4'h1;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Number of bytes in each extended length and in the masking key.
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   // One delivered payload byte with its frame markers.
   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] data;
      logic                 last;
      logic                 fin;
   } wsfd_beat_type;

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received WebSocket frames and delivers the unmasked payload bytes of
// frames with the selected opcode.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while the input is not
// stalled. Each payload byte of an accepted frame appears on the result
// stream in the cycle after its transfer in, held in a single output register;
// the input stalls only while that register is full and not being taken.
// Header bytes, length bytes, masking key bytes and payload bytes of frames
// with any other opcode produce no result, nor do zero-length frames. The
// opcode register is sampled at each frame's first header byte.
module websocket_frame_deframer
   import wsfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Received bytes.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   // Delivered payload.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] payload_byte
   output logic                   rsp_tlast,   // frame_last
   output logic                   rsp_tuser,   // [0] frame_fin
   // Accepted opcode register.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [OpcodeWidth-1:0] csr_data
);

   logic [OpcodeWidth-1:0] opcode_ff;
   wsfd_beat_type          beat;
   logic                   req_xfer;
   logic                   out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0]   out_data_ff;
   logic                   out_last_ff;
   logic                   out_fin_ff;

   // Accept a byte whenever the output register is free or drains this cycle.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Accepted opcode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff <= OPCODE_RESET;
      end else if (csr_valid) begin
         opcode_ff <= csr_data;
      end
   end

   wsfd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_xfer),
      .in_byte         (req_tdata),
      .accepted_opcode (opcode_ff),
      .beat            (beat)
   );

   // Output register: load a new beat, or empty once the last one is taken.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (beat.valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (beat.valid) begin
         out_data_ff <= beat.data;
         out_last_ff <= beat.last;
         out_fin_ff  <= beat.fin;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_fin_ff;

   // A new result only ever follows a transfer in.
   a_rsp_from_req : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result appeared without an input transfer");

   // The parser never issues a beat for a byte that was not transferred.
   a_beat_needs_xfer : assert property (@(posedge clock) disable iff (reset)
      beat.valid |-> (req_tvalid && req_tready))
      else $error("parser beat without an input transfer");

   // The opcode register comes out of reset selecting text frames.
   a_opcode_reset : assert property (@(posedge clock)
      $past(reset) |-> (opcode_ff == OPCODE_RESET))
      else $error("opcode register not at its reset value");

   // Output register leaves reset empty.
   a_out_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid directly after reset");

endmodule

// ===== hw/rtl/wsfd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame header parser
// Walks the frame header one byte at a time, collects the length and masking
// key, and unmasks payload bytes of frames whose opcode is accepted.
// ----------------------------------------------------------------------------
module wsfd_parser
   import wsfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [ByteWidth-1:0]   in_byte,
   input  logic [OpcodeWidth-1:0] accepted_opcode,
   output wsfd_beat_type          beat
);

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASKKEY = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   phase_type           phase_ff,     phase_in;
   logic [3:0]          ext_left_ff,  ext_left_in;
   logic [2:0]          key_left_ff,  key_left_in;
   logic [LenWidth-1:0] remaining_ff, remaining_in;
   logic [KeyWidth-1:0] key_ff,       key_in;
   logic [1:0]          key_pos_ff,   key_pos_in;
   logic                masked_ff,    masked_in;
   logic                fin_ff,       fin_in;
   logic                accepted_ff,  accepted_in;

   logic [6:0]           len7;
   logic [3:0]           ext_left_dec;
   logic [2:0]           key_left_dec;
   logic [ByteWidth-1:0] key_byte;
   logic                 len_done;

   // Next-state logic for one received byte.
   always_comb begin
      phase_in     = phase_ff;
      ext_left_in  = ext_left_ff;
      key_left_in  = key_left_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      key_pos_in   = key_pos_ff;
      masked_in    = masked_ff;
      fin_in       = fin_ff;
      accepted_in  = accepted_ff;
      beat         = '0;
      len_done     = 1'b0;
      len7         = in_byte[6:0];
      ext_left_dec = (ext_left_ff != 4'd0) ? ext_left_ff - 4'd1 : 4'd0;
      key_left_dec = (key_left_ff != 3'd0) ? key_left_ff - 3'd1 : 3'd0;

      // The key byte in use sits highest first in the key register.
      case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      case (phase_ff)
         PH_HDR1: begin
            masked_in    = in_byte[7];
            key_in       = '0;
            remaining_in = '0;
            if (len7 == LEN_CODE_EXT16) begin
               ext_left_in = EXT16_BYTES;
               phase_in    = PH_EXTLEN;
            end else if (len7 == LEN_CODE_EXT64) begin
               ext_left_in = EXT64_BYTES;
               phase_in    = PH_EXTLEN;
            end else begin
               remaining_in = LenWidth'(len7);
               len_done     = 1'b1;
            end
         end
         PH_EXTLEN: begin
            remaining_in = {remaining_ff[LenWidth-ByteWidth-1:0], in_byte};
            ext_left_in  = ext_left_dec;
            len_done     = (ext_left_dec == 4'd0);
         end
         PH_MASKKEY: begin
            key_in      = {key_ff[KeyWidth-ByteWidth-1:0], in_byte};
            key_left_in = key_left_dec;
            if (key_left_dec == 3'd0) begin
               if (remaining_ff == '0) begin
                  phase_in = PH_HDR0;
               end else begin
                  key_pos_in = 2'd0;
                  phase_in   = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            beat.valid   = in_valid & accepted_ff;
            beat.data    = masked_ff ? (in_byte ^ key_byte) : in_byte;
            beat.last    = (remaining_ff[LenWidth-1:1] == '0);
            beat.fin     = fin_ff;
            key_pos_in   = key_pos_ff + 2'd1;
            remaining_in = (remaining_ff != '0) ? remaining_ff - LenWidth'(1) : '0;
            if (remaining_in == '0) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            // First header byte; unused phase codes also land here.
            fin_in      = in_byte[7];
            accepted_in = (in_byte[OpcodeWidth-1:0] == accepted_opcode);
            phase_in    = PH_HDR1;
         end
      endcase

      // Once the length is known, move on to the key, the payload or a new frame.
      if (len_done) begin
         if (masked_in) begin
            key_left_in = KEY_BYTES;
            phase_in    = PH_MASKKEY;
         end else if (remaining_in == '0) begin
            phase_in = PH_HDR0;
         end else begin
            key_pos_in = 2'd0;
            phase_in   = PH_PAYLOAD;
         end
      end
   end

   // Parser state advances on every transfer into the block.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         ext_left_ff  <= '0;
         key_left_ff  <= '0;
         remaining_ff <= '0;
         key_ff       <= '0;
         key_pos_ff   <= '0;
         masked_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         accepted_ff  <= 1'b0;
      end else if (in_valid) begin
         phase_ff     <= phase_in;
         ext_left_ff  <= ext_left_in;
         key_left_ff  <= key_left_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         key_pos_ff   <= key_pos_in;
         masked_ff    <= masked_in;
         fin_ff       <= fin_in;
         accepted_ff  <= accepted_in;
      end
   end

endmodule
